@@ rtl/fmcd_pkg.sv @@
package fmcd_pkg;

   localparam int unsigned FrameLen = 13;
   localparam int unsigned StoreLen = FrameLen - 1;
   localparam int unsigned CountW   = $clog2(FrameLen);

   localparam logic [7:0] SyncByte   = 8'hFF;
   localparam logic [7:0] EndByte    = 8'hEF;
   localparam logic [7:0] CodeOn     = 8'h11;
   localparam logic [7:0] CodeIn     = 8'h10;
   localparam logic [7:0] ReloadInit = 8'd230;
   localparam logic [7:0] DutyInit   = 8'd255;

   typedef enum logic [1:0] {
      OP_BYTE     = 2'd0,
      OP_INT_LIM  = 2'd1,
      OP_EXT_LIM  = 2'd2,
      OP_UNUSED   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      NOTE_NONE    = 2'd0,
      NOTE_INT_LIM = 2'd1,
      NOTE_EXT_LIM = 2'd2
   } note_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       frame_done;
      logic       led_on;
      logic       motor_enable;
      logic       motor_dir;
      logic [7:0] step_reload;
      logic [7:0] pwm_duty;
      logic       dac_strobe;
      logic [7:0] dac_high;
      logic [7:0] dac_low;
      logic       adc_request;
      logic [1:0] notify;
   } rsp_type;

endpackage

@@ rtl/framed_motor_command_decoder_top.sv @@
// channel | direction | handshake              | payload
// req     | in        | req_valid / req_ready  | req  (op, rx_byte)
// rsp     | out       | rsp_valid / rsp_ready  | rsp  (frame_done .. notify)
//
// One request per cycle while req_ready is high; its response is registered in main or skid.
// Decode is a single pass from the request and the held state into the response register.
// A two-entry output register (main plus skid) lets a request be taken while a
// response waits; req_ready drops only when both entries are full.
// Synchronous active-high reset clears the frame count, motor/LED state and
// loads reload 230, duty 255; collected frame bytes are not reset.
module framed_motor_command_decoder_top
   import fmcd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   logic [CountW-1:0] count_ff, count_in;
   logic [7:0]        bytes_ff [StoreLen];
   logic              led_ff, led_in;
   logic              en_ff, en_in;
   logic              dir_ff, dir_in;
   logic [7:0]        reload_ff, reload_in;
   logic [7:0]        duty_ff, duty_in;

   logic              wr_en;
   logic              accept;
   rsp_type           res;

   rsp_type           main_ff, skid_ff;
   logic              main_valid_ff, skid_valid_ff;

   assign accept    = req_valid && req_ready;
   assign req_ready = !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp       = main_ff;

   always_comb begin
      logic frame_ok;
      count_in  = count_ff;
      led_in    = led_ff;
      en_in     = en_ff;
      dir_in    = dir_ff;
      reload_in = reload_ff;
      duty_in   = duty_ff;
      wr_en     = 1'b0;
      frame_ok  = 1'b0;
      res       = '0;
      unique case (op_type'(req.op))
         OP_BYTE: begin
            if (count_ff == '0 && req.rx_byte != SyncByte) begin
               count_in = count_ff;
            end else if (count_ff < CountW'(StoreLen)) begin
               wr_en    = 1'b1;
               count_in = count_ff + CountW'(1);
            end else begin
               count_in = '0;
               frame_ok = bytes_ff[0] == SyncByte && bytes_ff[1] == SyncByte &&
                          bytes_ff[11] == EndByte && req.rx_byte == EndByte;
            end
            if (frame_ok) begin
               res.frame_done  = 1'b1;
               res.adc_request = bytes_ff[2] == CodeOn;
               led_in          = bytes_ff[3] == CodeOn;
               res.dac_strobe  = led_in;
               res.dac_high    = led_in ? bytes_ff[9] : 8'd0;
               res.dac_low     = led_in ? bytes_ff[10] : 8'd0;
               en_in           = bytes_ff[4] == CodeOn;
               if (en_in && bytes_ff[5] == CodeOn) begin
                  dir_in = 1'b0;
               end else if (en_in && bytes_ff[5] == CodeIn) begin
                  dir_in = 1'b1;
               end
               reload_in = bytes_ff[6];
               duty_in   = bytes_ff[7];
            end
         end
         OP_INT_LIM: begin
            if (dir_ff) begin
               dir_in     = 1'b0;
               en_in      = 1'b0;
               res.notify = NOTE_INT_LIM;
            end
         end
         OP_EXT_LIM: begin
            if (!dir_ff) begin
               dir_in     = 1'b1;
               en_in      = 1'b0;
               res.notify = NOTE_EXT_LIM;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      res.led_on       = led_in;
      res.motor_enable = en_in;
      res.motor_dir    = dir_in;
      res.step_reload  = reload_in;
      res.pwm_duty     = duty_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         led_ff    <= 1'b0;
         en_ff     <= 1'b0;
         dir_ff    <= 1'b0;
         reload_ff <= ReloadInit;
         duty_ff   <= DutyInit;
      end else if (accept) begin
         count_ff  <= count_in;
         led_ff    <= led_in;
         en_ff     <= en_in;
         dir_ff    <= dir_in;
         reload_ff <= reload_in;
         duty_ff   <= duty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         bytes_ff[count_ff] <= req.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_ready || !main_valid_ff) begin
         main_valid_ff <= skid_valid_ff || accept;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready || !main_valid_ff) begin
         main_ff <= skid_valid_ff ? skid_ff : res;
      end else if (accept) begin
         skid_ff <= res;
      end
   end

endmodule

@@ rtl/fmcd_checker.sv @@
module fmcd_checker
   import fmcd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("response changed while stalled");

   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.dac_strobe |-> rsp.frame_done && rsp.led_on)
      else $error("dac strobe without frame or led");

   a_dac_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.dac_strobe |-> rsp.dac_high == 8'd0 && rsp.dac_low == 8'd0)
      else $error("dac bytes without strobe");

   a_int_lim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.notify == NOTE_INT_LIM |-> !rsp.motor_dir && !rsp.motor_enable)
      else $error("internal limit left motor running");

   a_ext_lim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.notify == NOTE_EXT_LIM |-> rsp.motor_dir && !rsp.motor_enable)
      else $error("external limit left motor running");

endmodule

bind framed_motor_command_decoder_top fmcd_checker u_fmcd_checker (.*);

@@ bench/fmcd_response_check.sv @@
`timescale 1ns / 100ps

module fmcd_response_check
   import fmcd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp,
   output int      errors,
   output int      pending,
   output int      checked,
   output int      frames,
   output int      reports
);

   logic [CountW-1:0] byte_count;
   logic [7:0]        held_bytes [StoreLen];
   logic              led_level;
   logic              enable_level;
   logic              dir_level;
   logic [7:0]        reload_level;
   logic [7:0]        duty_level;

   rsp_type predicted_rsp_q [$];

   initial begin
      errors  = 0;
      pending = 0;
      checked = 0;
      frames  = 0;
      reports = 0;
   end

   // predicted decoder response; updates the shadow state
   function automatic rsp_type decode_request(req_type r);
      rsp_type o;
      o = '0;
      case (op_type'(r.op))
         OP_BYTE: begin
            if (byte_count != 0 || r.rx_byte == SyncByte) begin
               if (byte_count < StoreLen) begin
                  held_bytes[byte_count] = r.rx_byte;
                  byte_count = byte_count + 1'b1;
               end else begin
                  byte_count = '0;
                  if (held_bytes[0] == SyncByte && held_bytes[1] == SyncByte &&
                      held_bytes[11] == EndByte && r.rx_byte == EndByte) begin
                     o.frame_done  = 1'b1;
                     o.adc_request = (held_bytes[2] == CodeOn);
                     if (held_bytes[3] == CodeOn) begin
                        led_level    = 1'b1;
                        o.dac_strobe = 1'b1;
                        o.dac_high   = held_bytes[9];
                        o.dac_low    = held_bytes[10];
                     end else begin
                        led_level = 1'b0;
                     end
                     if (held_bytes[4] == CodeOn) begin
                        if (held_bytes[5] == CodeOn)
                           dir_level = 1'b0;
                        else if (held_bytes[5] == CodeIn)
                           dir_level = 1'b1;
                        enable_level = 1'b1;
                     end else begin
                        enable_level = 1'b0;
                     end
                     reload_level = held_bytes[6];
                     duty_level   = held_bytes[7];
                  end
               end
            end
         end
         OP_INT_LIM: begin
            if (dir_level) begin
               dir_level    = 1'b0;
               enable_level = 1'b0;
               o.notify     = NOTE_INT_LIM;
            end
         end
         OP_EXT_LIM: begin
            if (!dir_level) begin
               enable_level = 1'b0;
               dir_level    = 1'b1;
               o.notify     = NOTE_EXT_LIM;
            end
         end
         default: begin
         end
      endcase
      o.led_on       = led_level;
      o.motor_enable = enable_level;
      o.motor_dir    = dir_level;
      o.step_reload  = reload_level;
      o.pwm_duty     = duty_level;
      return o;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         byte_count   = '0;
         led_level    = 1'b0;
         enable_level = 1'b0;
         dir_level    = 1'b0;
         reload_level = ReloadInit;
         duty_level   = DutyInit;
         predicted_rsp_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp_q.size() == 0) begin
               $error("unexpected response, none pending");
               errors++;
            end else begin
               want = predicted_rsp_q.pop_front();
               check_field("frame_done",   want.frame_done,   rsp.frame_done);
               check_field("led_on",       want.led_on,       rsp.led_on);
               check_field("motor_enable", want.motor_enable, rsp.motor_enable);
               check_field("motor_dir",    want.motor_dir,    rsp.motor_dir);
               check_field("step_reload",  want.step_reload,  rsp.step_reload);
               check_field("pwm_duty",     want.pwm_duty,     rsp.pwm_duty);
               check_field("dac_strobe",   want.dac_strobe,   rsp.dac_strobe);
               check_field("dac_high",     want.dac_high,     rsp.dac_high);
               check_field("dac_low",      want.dac_low,      rsp.dac_low);
               check_field("adc_request",  want.adc_request,  rsp.adc_request);
               check_field("notify",       want.notify,       rsp.notify);
               checked++;
            end
         end
         if (req_valid && req_ready) begin
            want = decode_request(req);
            if (want.frame_done)
               frames++;
            if (want.notify != NOTE_NONE)
               reports++;
            predicted_rsp_q.push_back(want);
         end
      end
      pending = predicted_rsp_q.size();
   end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import fmcd_pkg::*;

   localparam int CycleLimit  = 300000;
   localparam int RandomItems = 650;

   typedef logic [7:0] frame_type [FrameLen];

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp;

   int errors;
   int pending;
   int checked;
   int frames;
   int reports;
   int sent;
   int burst_left;

   framed_motor_command_decoder_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   fmcd_response_check resp_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .errors    (errors),
      .pending   (pending),
      .checked   (checked),
      .frames    (frames),
      .reports   (reports)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   // response side stalls on its own changing pattern
   initial begin
      int          mode;
      int          mode_left;
      int          idx;
      logic [31:0] pattern;
      mode      = 0;
      mode_left = 0;
      idx       = 0;
      pattern   = '1;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(8, 60);
            pattern   = $urandom;
         end
         mode_left--;
         idx++;
         case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= pattern[idx % 32];
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic send_request(input op_type op, input logic [7:0] data);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req       <= '{op: op, rx_byte: data};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] rand_code();
      case ($urandom_range(0, 3))
         0, 1:    return CodeOn;
         2:       return CodeIn;
         default: return rand_byte();
      endcase
   endfunction

   // limit events and unused ops may land between frame bytes
   task automatic send_frame(input frame_type f, input bit mix_events);
      for (int i = 0; i < FrameLen; i++) begin
         if (mix_events && $urandom_range(0, 15) == 0)
            send_request(op_type'($urandom_range(1, 3)), 8'($urandom));
         send_request(OP_BYTE, f[i]);
      end
   endtask

   task automatic send_random_frame(input bit broken);
      frame_type f;
      int        pos;
      f[0] = SyncByte;
      f[1] = SyncByte;
      for (int i = 2; i < 6; i++)
         f[i] = rand_code();
      for (int i = 6; i < 11; i++)
         f[i] = rand_byte();
      f[11] = EndByte;
      f[12] = EndByte;
      if (broken) begin
         case ($urandom_range(0, 3))
            0:       pos = 0;
            1:       pos = 1;
            2:       pos = 11;
            default: pos = 12;
         endcase
         f[pos] = f[pos] ^ (8'($urandom_range(1, 255)));
      end
      send_frame(f, 1'b1);
   endtask

   // non-sync filler: finishes any partial frame, then is dropped
   task automatic send_resync();
      repeat (FrameLen) send_request(OP_BYTE, 8'h00);
   endtask

   initial begin
      frame_type directed;
      int        kind;
      int        n;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req          = '0;
      sent         = 0;
      burst_left   = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_request(OP_BYTE, 8'h00);
      send_request(OP_UNUSED, 8'hFF);
      send_request(OP_INT_LIM, 8'h00);
      send_request(OP_EXT_LIM, 8'hFF);
      send_request(OP_EXT_LIM, 8'h00);
      send_request(OP_INT_LIM, 8'hFF);
      directed = '{SyncByte, SyncByte, CodeOn, CodeOn, CodeOn, CodeIn, 8'h00, 8'h00,
                   8'hA5, 8'hFF, 8'h00, EndByte, EndByte};
      send_frame(directed, 1'b0);
      send_request(OP_EXT_LIM, 8'h5A);
      send_request(OP_INT_LIM, 8'hA5);

      while (sent < RandomItems) begin
         kind = $urandom_range(0, 19);
         if (kind < 14) begin
            send_random_frame(1'b0);
         end else if (kind < 16) begin
            send_random_frame(1'b1);
            send_resync();
         end else if (kind < 18) begin
            send_request(op_type'($urandom_range(1, 2)), 8'($urandom));
         end else if (kind == 18) begin
            n = $urandom_range(1, 4);
            repeat (n) send_request(OP_BYTE, 8'($urandom));
            send_resync();
         end else begin
            send_request(OP_UNUSED, 8'($urandom));
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      $display("Sent %0d requests; %0d responses checked.", sent, checked);
      $display("Decoded %0d good frames and %0d limit reports.", frames, reports);
      if (errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/fmcd_pkg.sv
rtl/framed_motor_command_decoder_top.sv
rtl/fmcd_checker.sv
bench/fmcd_response_check.sv
bench/tb.sv
